// File: sv/ppg_pkg.sv
// Package for the plasma pixel generator: fixed-point constants, shared types,
// the sine table entry function and the channel byte mapping.
// No dependencies.
package ppg_pkg;

  localparam int IMAGE_WIDTH_DEF  = 128;
  localparam int IMAGE_HEIGHT_DEF = 128;
  localparam int SINE_DEPTH_DEF   = 1024;

  // Angles in Q.16 radians.
  localparam int PI_Q      = 205887;
  localparam int TWOPI_Q   = 411774;
  localparam int HALFPI_Q  = 102943;
  localparam int FOURPI_Q  = 823550;
  localparam int PHASE_G_Q = 135886;
  localparam int PHASE_B_Q = 271771;
  localparam int C033_Q    = 21627;

  // Every sine argument that could go negative gets this multiple of 2pi added so that it is never negative.
  localparam int ANG_OFF = 4 * TWOPI_Q;

  localparam int ANG_W     = 31;  // width of an offset, non-negative angle
  localparam int RED_W     = 19;  // width of an angle reduced into [0, 2pi)
  localparam int SIN_W     = 16;  // signed Q1.14 sine
  localparam int RECIP_S   = 40;  // shift of the 1/2pi reciprocal
  localparam int RECIP_M_W = 22;  // width of the 1/2pi reciprocal
  localparam int CX_W      = 28;  // signed width of the centre offsets
  localparam int ISQ_W     = 64;
  localparam int ISQ_STEPS = 32;
  localparam int MAP_N     = 128; // number of column or row codes

  typedef logic [ANG_W-1:0]        uang_t;
  typedef logic signed [SIN_W-1:0] sin_t;
  typedef logic signed [31:0]      sang_t;
  typedef sang_t                   map_tab_t [MAP_N];

  // Q1.14 sine of a quantized angle in [0, 2pi), by quarter-wave folding and a
  // Taylor series to the ninth power.
  function automatic sin_t sin_entry(input longint a_in);
    longint a;
    longint x2;
    longint term;
    longint sum;
    longint q;
    logic   neg;
    a   = a_in;
    neg = 1'b0;
    if (a >= PI_Q) begin
      neg = 1'b1;
      a   = a - PI_Q;
    end
    if (a > HALFPI_Q) begin
      a = PI_Q - a;
    end
    x2   = (a * a) >>> 16;
    term = a;
    sum  = a;
    term = ((term * x2) >>> 16) / 6;
    sum  = sum - term;
    term = ((term * x2) >>> 16) / 20;
    sum  = sum + term;
    term = ((term * x2) >>> 16) / 42;
    sum  = sum - term;
    term = ((term * x2) >>> 16) / 72;
    sum  = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    q = (sum + 2) >>> 2;
    if (q > 16384) begin
      q = 16384;
    end
    return neg ? SIN_W'(-q) : SIN_W'(q);
  endfunction

  // Maps a sine in [-1, 1] onto a byte, clamped at 255.
  function automatic logic [7:0] chan_byte(input sin_t s);
    logic signed [SIN_W:0] vs;
    logic [24:0]           c;
    logic [9:0]            cs;
    vs = (SIN_W+1)'(s) + (SIN_W+1)'(16384);
    c  = 25'(vs[SIN_W-1:0]) * 25'd255;
    cs = c[24:15];
    return (cs > 10'd255) ? 8'd255 : cs[7:0];
  endfunction

endpackage

// File: sv/ppg_delay.sv
// Fixed-length delay line that keeps side data in step with the pipeline.
// Depends on nothing; advances only when the pipeline advances.
module ppg_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule

// File: sv/ppg_sine_rom.sv
// Constant quantized sine table with a registered read port.
// Depends on ppg_pkg for the entry function and the angle constants.
module ppg_sine_rom import ppg_pkg::*; #(
  parameter int DEPTH = SINE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  output sin_t                     data
);

  typedef sin_t rom_t [DEPTH];

  // Entry p holds the sine of the phase step p mapped back to radians.
  function automatic rom_t build_rom();
    rom_t tab;
    for (int i = 0; i < DEPTH; i++) begin
      tab[i] = sin_entry((longint'(i) * TWOPI_Q) / DEPTH);
    end
    return tab;
  endfunction

  localparam rom_t ROM = build_rom();

  sin_t data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= ROM[addr];
    end
  end

  assign data = data_r;

endmodule

// File: sv/ppg_sin_unit.sv
// Seven-stage sine unit: reduces a non-negative angle modulo 2pi, quantizes
// it to a table step by reciprocal multiplication and reads the sine table.
// Depends on ppg_pkg and ppg_sine_rom.
module ppg_sin_unit import ppg_pkg::*; #(
  parameter int DEPTH = SINE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  vld_i,
  input  uang_t ang_i,
  output logic  vld_o,
  output sin_t  sin_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int P1W = ANG_W + RECIP_M_W;
  localparam int MW = RED_W + AW;
  localparam int P2W = RED_W + RECIP_M_W + AW + 1;
  localparam longint unsigned RM = (64'd1 << RECIP_S) / TWOPI_Q;
  localparam longint unsigned RMD = RM * DEPTH;

  logic [6:0]         vld_r;
  uang_t              a1_r;
  logic [P1W-1:0]     prod1_r;
  logic [RED_W:0]     r1_r;
  logic [RED_W-1:0]   r2_r;
  logic [MW-1:0]      m_r;
  logic [P2W-1:0]     prod2_r;
  logic [AW-1:0]      pe_r;
  logic [RED_W:0]     rem_r;
  logic [AW-1:0]      addr_r;

  logic [ANG_W-RECIP_S+RECIP_M_W-1:0] q1;
  uang_t          r1_full;
  logic [AW-1:0]  pe;
  logic [MW-1:0]  rem_full;

  // The reciprocal estimates come out exact or one short; one compare fixes them.
  assign q1       = prod1_r[P1W-1:RECIP_S];
  assign r1_full  = a1_r - ANG_W'(q1) * ANG_W'(TWOPI_Q);
  assign pe       = prod2_r[RECIP_S +: AW];
  assign rem_full = m_r - MW'(pe) * MW'(TWOPI_Q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r    <= ang_i;
      prod1_r <= P1W'(ang_i) * P1W'(RM);
      r1_r    <= r1_full[RED_W:0];
      r2_r    <= (r1_r >= (RED_W+1)'(TWOPI_Q)) ? RED_W'(r1_r - (RED_W+1)'(TWOPI_Q))
                                               : r1_r[RED_W-1:0];
      m_r     <= MW'(r2_r) * MW'(DEPTH);
      prod2_r <= P2W'(r2_r) * P2W'(RMD);
      pe_r    <= pe;
      rem_r   <= rem_full[RED_W:0];
      addr_r  <= (rem_r >= (RED_W+1)'(TWOPI_Q)) ? pe_r + AW'(1) : pe_r;
    end
  end

  ppg_sine_rom #(
    .DEPTH (DEPTH)
  ) u_rom (
    .clk  (clk),
    .en   (en),
    .addr (addr_r),
    .data (sin_o)
  );

  assign vld_o = vld_r[6];

endmodule

// File: sv/ppg_isqrt.sv
// Pipelined bitwise integer square root, one result bit per register stage.
// Depends on ppg_pkg for the word width and the step count.
module ppg_isqrt import ppg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_i,
  input  logic [ISQ_W-1:0] val_i,
  output logic             vld_o,
  output logic [ISQ_W-1:0] root_o
);

  logic [ISQ_STEPS-1:0] vld_r;
  logic [ISQ_W-1:0]     res_r [ISQ_STEPS];
  logic [ISQ_W-1:0]     rem_r [ISQ_STEPS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ISQ_STEPS-2:0], vld_i};
    end
  end

  for (genvar g = 0; g < ISQ_STEPS; g++) begin : g_step
    localparam logic [ISQ_W-1:0] BIT = ISQ_W'(1) << (ISQ_W - 2 - 2 * g);
    logic [ISQ_W-1:0] rem_in;
    logic [ISQ_W-1:0] res_in;
    logic [ISQ_W-1:0] trial;
    logic             take;

    if (g == 0) begin : g_first
      assign rem_in = val_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign res_in = res_r[g-1];
    end

    assign trial = res_in + BIT;
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        res_r[g] <= take ? (res_in >> 1) + BIT : (res_in >> 1);
      end
    end

    // The remainder is not needed after the last step.
    if (g < ISQ_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g] <= take ? rem_in - trial : rem_in;
        end
      end
    end
  end

  assign vld_o  = vld_r[ISQ_STEPS-1];
  assign root_o = res_r[ISQ_STEPS-1];

endmodule

// File: sv/plasma_pixel_generator.sv
// Plasma pixel generator: one RGB word of an animated plasma per input word.
// Depends on ppg_pkg, ppg_sin_unit, ppg_isqrt and ppg_delay.
//
// Usage:
//   The slave channel (in_*) takes one word per pixel: column, row and the
//   frame time in unsigned Q12.12 seconds. The master channel (out_*) returns
//   one word with the red, green and blue bytes, in input order.
//   The whole datapath is one pipeline with a valid bit per stage. A new
//   word is taken every cycle while in_tready is high, so throughput is
//   one pixel per clock.
//   The depth is set by the 32-stage square root of the radius and the three
//   seven-stage sine units in series (phase reduction plus table read).
//   A two-entry output queue sits behind the pipeline: while the receiver
//   holds out_tready low the pipeline keeps running until the second entry
//   fills, then the whole pipeline freezes and in_tready goes low. Nothing is
//   lost or repeated across a stall.
//   Reset (rst_n low at a clock edge) clears all valid bits and the queue; no
//   table or memory needs a clearing pass.
module plasma_pixel_generator import ppg_pkg::*; #(
  parameter int IMAGE_WIDTH      = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT     = IMAGE_HEIGHT_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // column[6:0], row[13:7], frame_time[37:14], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  function automatic map_tab_t build_xmap();
    map_tab_t tab;
    for (int i = 0; i < MAP_N; i++) begin
      tab[i] = 32'((longint'(i) * FOURPI_Q) / IMAGE_WIDTH - FOURPI_Q);
    end
    return tab;
  endfunction

  function automatic map_tab_t build_ymap();
    map_tab_t tab;
    for (int i = 0; i < MAP_N; i++) begin
      tab[i] = 32'((longint'(i) * FOURPI_Q) / IMAGE_HEIGHT - FOURPI_Q);
    end
    return tab;
  endfunction

  localparam map_tab_t XMAP = build_xmap();
  localparam map_tab_t YMAP = build_ymap();

  logic en;

  // Input and argument stages.
  logic  v1_r, v2_r, v3_r;
  sang_t x1_r, y1_r, t1_r;
  sang_t x2_r, y2_r, t2_r;
  sang_t x3_r, y3_r, t3_r;
  uang_t ay2_r, axt2_r, axyt2_r, ac2_r;
  uang_t ay3_r, axt3_r, axyt3_r, ac3_r, as3_r;
  logic [42:0] tc2_r;
  sang_t ay, axt, axyt, ac;

  // First sine bank.
  logic  vs10;
  sin_t  s_y, s_xt, s_xyt, s_s033, s_c05;
  sang_t x10, y10, t10;

  // Centre and radius stages.
  logic  v11_r, v12_r, v13_r, v14_r;
  logic signed [35:0] cxp11_r, cyp11_r;
  logic signed [17:0] sum3_11_r, sum3_12_r, sum3_13_r, sum3_14_r;
  sang_t x11_r, y11_r, t11_r, t12_r, t13_r, t14_r;
  logic signed [CX_W-1:0]   cx12_r, cy12_r;
  logic signed [2*CX_W-1:0] sqx, sqy;
  logic [2*CX_W-1:0]        sqx13_r, sqy13_r;
  logic [ISQ_W-1:0]         r2_14_r;

  // Square root and the distance sine.
  logic               vq;
  logic [ISQ_W-1:0]   root;
  logic signed [17:0] sum3_q;
  sang_t              t_q;
  sang_t              ad;
  logic               v15_r;
  uang_t              ad15_r;
  logic signed [17:0] sum3_15_r;
  logic               vc;
  sin_t               s_d;
  logic signed [17:0] sum3_c;

  // Plasma value and the channel sines.
  logic               v16_r, v17_r, v18_r;
  logic signed [18:0] sum16_r;
  logic signed [37:0] pa17_r;
  sang_t              a_base, ar, ag, ab;
  uang_t              ar18_r, ag18_r, ab18_r;
  logic               vo;
  sin_t               s_r, s_g, s_b;

  // Output queue.
  logic        push, pop;
  logic [23:0] chan;
  logic [23:0] o_r, sk_r;
  logic        ov_r, skv_r;
  logic        ov_nxt, skv_nxt, load_o, load_sk;
  logic [23:0] o_nxt;

  assign en        = !skv_r;
  assign in_tready = en;

  assign ay   = y1_r + t1_r + ANG_OFF;
  assign axt  = ((x1_r + t1_r) >>> 1) + ANG_OFF;
  assign axyt = ((x1_r + y1_r + t1_r) >>> 1) + ANG_OFF;
  assign ac   = (t1_r >>> 1) + HALFPI_Q;

  assign sqx = cx12_r * cx12_r;
  assign sqy = cy12_r * cy12_r;

  assign ad = $signed(root[31:0]) + t_q + ANG_OFF;

  assign a_base = 32'(pa17_r >>> 15) + ANG_OFF;
  assign ar     = a_base;
  assign ag     = a_base + PHASE_G_Q;
  assign ab     = a_base + PHASE_B_Q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v11_r <= 1'b0;
      v12_r <= 1'b0;
      v13_r <= 1'b0;
      v14_r <= 1'b0;
      v15_r <= 1'b0;
      v16_r <= 1'b0;
      v17_r <= 1'b0;
      v18_r <= 1'b0;
    end else if (en) begin
      v1_r  <= in_tvalid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v11_r <= vs10;
      v12_r <= v11_r;
      v13_r <= v12_r;
      v14_r <= v13_r;
      v15_r <= vq;
      v16_r <= vc;
      v17_r <= v16_r;
      v18_r <= v17_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= XMAP[in_tdata[6:0]];
      y1_r <= YMAP[in_tdata[13:7]];
      t1_r <= $signed({4'b0, in_tdata[37:14], 4'b0});

      ay2_r   <= ay[ANG_W-1:0];
      axt2_r  <= axt[ANG_W-1:0];
      axyt2_r <= axyt[ANG_W-1:0];
      ac2_r   <= ac[ANG_W-1:0];
      tc2_r   <= 43'(t1_r[27:0]) * 43'(C033_Q);
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      t2_r    <= t1_r;

      ay3_r   <= ay2_r;
      axt3_r  <= axt2_r;
      axyt3_r <= axyt2_r;
      ac3_r   <= ac2_r;
      as3_r   <= ANG_W'(tc2_r[42:16]);
      x3_r    <= x2_r;
      y3_r    <= y2_r;
      t3_r    <= t2_r;

      cxp11_r   <= 36'(s_s033) * 36'(TWOPI_Q);
      cyp11_r   <= 36'(s_c05) * 36'(TWOPI_Q);
      sum3_11_r <= 18'(s_y) + 18'(s_xt) + 18'(s_xyt);
      x11_r     <= x10;
      y11_r     <= y10;
      t11_r     <= t10;

      cx12_r    <= CX_W'(x11_r + 32'(cxp11_r >>> 14));
      cy12_r    <= CX_W'(y11_r + 32'(cyp11_r >>> 14));
      sum3_12_r <= sum3_11_r;
      t12_r     <= t11_r;

      sqx13_r   <= sqx;
      sqy13_r   <= sqy;
      sum3_13_r <= sum3_12_r;
      t13_r     <= t12_r;

      r2_14_r   <= ISQ_W'(sqx13_r) + ISQ_W'(sqy13_r) + (ISQ_W'(1) << 32);
      sum3_14_r <= sum3_13_r;
      t14_r     <= t13_r;

      ad15_r    <= ad[ANG_W-1:0];
      sum3_15_r <= sum3_q;

      sum16_r <= 19'(sum3_c) + 19'(s_d);
      pa17_r  <= 38'(sum16_r) * 38'(PI_Q);

      ar18_r <= ar[ANG_W-1:0];
      ag18_r <= ag[ANG_W-1:0];
      ab18_r <= ab[ANG_W-1:0];
    end
  end

  ppg_sin_unit #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_y (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(v3_r), .ang_i(ay3_r),
    .vld_o(vs10), .sin_o(s_y)
  );

  ppg_sin_unit #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_xt (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(v3_r), .ang_i(axt3_r),
    .vld_o(), .sin_o(s_xt)
  );

  ppg_sin_unit #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_xyt (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(v3_r), .ang_i(axyt3_r),
    .vld_o(), .sin_o(s_xyt)
  );

  ppg_sin_unit #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_s033 (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(v3_r), .ang_i(as3_r),
    .vld_o(), .sin_o(s_s033)
  );

  ppg_sin_unit #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_c05 (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(v3_r), .ang_i(ac3_r),
    .vld_o(), .sin_o(s_c05)
  );

  ppg_delay #(.W(96), .N(7)) u_dly_xyt (
    .clk(clk), .en(en), .d({x3_r, y3_r, t3_r}), .q({x10, y10, t10})
  );

  ppg_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(v14_r), .val_i(r2_14_r),
    .vld_o(vq), .root_o(root)
  );

  ppg_delay #(.W(50), .N(ISQ_STEPS)) u_dly_sq (
    .clk(clk), .en(en), .d({sum3_14_r, t14_r}), .q({sum3_q, t_q})
  );

  ppg_sin_unit #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_d (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(v15_r), .ang_i(ad15_r),
    .vld_o(vc), .sin_o(s_d)
  );

  ppg_delay #(.W(18), .N(7)) u_dly_sum (
    .clk(clk), .en(en), .d(sum3_15_r), .q(sum3_c)
  );

  ppg_sin_unit #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_r (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(v18_r), .ang_i(ar18_r),
    .vld_o(vo), .sin_o(s_r)
  );

  ppg_sin_unit #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_g (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(v18_r), .ang_i(ag18_r),
    .vld_o(), .sin_o(s_g)
  );

  ppg_sin_unit #(.DEPTH(SINE_TABLE_DEPTH)) u_sin_b (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(v18_r), .ang_i(ab18_r),
    .vld_o(), .sin_o(s_b)
  );

  assign chan = {chan_byte(s_b), chan_byte(s_g), chan_byte(s_r)};
  assign push = en && vo;
  assign pop  = ov_r && out_tready;

  // The second queue entry only fills while the first one is held.
  always_comb begin
    ov_nxt  = ov_r;
    skv_nxt = skv_r;
    load_o  = 1'b0;
    load_sk = 1'b0;
    o_nxt   = chan;
    if (skv_r) begin
      if (pop) begin
        load_o  = 1'b1;
        o_nxt   = sk_r;
        skv_nxt = 1'b0;
      end
    end else if (push) begin
      if (!ov_r || pop) begin
        load_o = 1'b1;
        ov_nxt = 1'b1;
      end else begin
        load_sk = 1'b1;
        skv_nxt = 1'b1;
      end
    end else if (pop) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      skv_r <= 1'b0;
    end else begin
      ov_r  <= ov_nxt;
      skv_r <= skv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_o) begin
      o_r <= o_nxt;
    end
    if (load_sk) begin
      sk_r <= chan;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = o_r;

endmodule
